// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the quantizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MMQP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MMQP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mmqp_pkg.sv =====
package mmqp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned QB_W = 5;
  localparam int unsigned CC_W = 3;

  localparam logic [QB_W-1:0] QB_MIN = 5'd2;
  localparam logic [QB_W-1:0] QB_MAX = 5'd16;
  localparam logic [QB_W-1:0] QB_RESET = 5'd8;
  localparam logic [CC_W-1:0] CC_RESET = 3'd1;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_SCAN  = 2'd1,
    REQ_QUANT = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  localparam logic REG_QUANT_BITS = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DIV
  } state_e;

endpackage

// ===== sv/min_max_quantize_pack.sv =====
// Per-channel min/max quantizer. A transaction is accepted when start is high while busy is
// low. A clear transaction resets the ranges at acceptance, a scan transaction then visits
// all MAX_CHANNELS channels. A quantize transaction walks the used channels through one
// shared compare unit and one shared restoring divider: a range check for each channel, and
// for each channel that needs a division, one quotient bit per divider step up to the effective
// code width, quant_bits clamped to 2..16. The result appears on packed_word_o and flat_range_o,
// marked by done_o high for a single cycle, in the cycle after the last channel finishes; the
// receiver cannot stall it, so it must take it then.
module min_max_quantize_pack #(
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic signed [31:0]            sample_ch0_i,
  input  logic signed [31:0]            sample_ch1_i,
  input  logic signed [31:0]            sample_ch2_i,
  input  logic signed [31:0]            sample_ch3_i,
  output logic                          done_o,
  output logic [mmqp_pkg::WORD_W-1:0]   packed_word_o,
  output logic                          flat_range_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  `include "assert_macros.svh"

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned LW = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int unsigned IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned OFF_W = $clog2(MAX_CHANNELS * mmqp_pkg::CODE_W + 1);
  localparam int unsigned CW = mmqp_pkg::CODE_W;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  mmqp_pkg::state_e state_q, state_d;

  logic [mmqp_pkg::QB_W-1:0] quant_bits_q;
  logic [mmqp_pkg::CC_W-1:0] channel_count_q;

  logic signed [SW-1:0] range_low_q [MAX_CHANNELS];
  logic signed [SW-1:0] range_high_q [MAX_CHANNELS];
  logic signed [SW-1:0] sample_q [MAX_CHANNELS];
  logic signed [SW-1:0] sample_in [MAX_CHANNELS];

  logic [CNT_W-1:0]  ch_q, ch_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [mmqp_pkg::WORD_W-1:0] word_q, word_d;
  logic              flat_q, flat_d;
  logic [SW-1:0]     rem_q, rem_d;
  logic [SW-1:0]     den_q, den_d;
  logic [CW-1:0]     quo_q, quo_d;
  logic [mmqp_pkg::QB_W-1:0] iter_q, iter_d;
  logic              done_q, done_d;
  logic [mmqp_pkg::WORD_W-1:0] packed_q, packed_d;
  logic              flat_out_q, flat_out_d;

  logic              accept;
  logic              cfg_write;
  logic [mmqp_pkg::QB_W-1:0] bits_eff;
  logic [CNT_W-1:0]  used;
  logic [CW-1:0]     top;
  logic [IW-1:0]     idx;
  logic signed [SW-1:0] v_sel, lo_sel, hi_sel;
  logic              is_flat, is_below, is_above;
  logic [SW:0]       num_wide, den_wide;
  logic [SW:0]       rem_sh;
  logic              rem_ge;
  logic              last_ch;
  logic              last_iter;
  logic              scan_last;
  logic              merge;
  logic [CW-1:0]     merge_code;
  logic              merge_flat;

  assign accept = start && !busy;
  assign busy = (state_q != mmqp_pkg::ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  assign prdata = (paddr[2] == mmqp_pkg::REG_CHANNEL_COUNT)
                ? {{(32-mmqp_pkg::CC_W){1'b0}}, channel_count_q}
                : {{(32-mmqp_pkg::QB_W){1'b0}}, quant_bits_q};

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      sample_in[c] = '0;
    end
    sample_in[0] = SW'(signed'(sample_ch0_i[LW-1:0]));
    if (MAX_CHANNELS > 1) begin
      sample_in[1 % MAX_CHANNELS] = SW'(signed'(sample_ch1_i[LW-1:0]));
    end
    if (MAX_CHANNELS > 2) begin
      sample_in[2 % MAX_CHANNELS] = SW'(signed'(sample_ch2_i[LW-1:0]));
    end
    if (MAX_CHANNELS > 3) begin
      sample_in[3 % MAX_CHANNELS] = SW'(signed'(sample_ch3_i[LW-1:0]));
    end
  end

  always_comb begin
    if (quant_bits_q < mmqp_pkg::QB_MIN) begin
      bits_eff = mmqp_pkg::QB_MIN;
    end else if (quant_bits_q > mmqp_pkg::QB_MAX) begin
      bits_eff = mmqp_pkg::QB_MAX;
    end else begin
      bits_eff = quant_bits_q;
    end
    if (channel_count_q == '0) begin
      used = CNT_W'(1);
    end else if (32'(channel_count_q) > MAX_CHANNELS) begin
      used = CNT_W'(MAX_CHANNELS);
    end else begin
      used = CNT_W'(channel_count_q);
    end
  end

  assign top = CW'((17'(1) << bits_eff) - 17'(1));

  // Shared compare unit: one channel per cycle, held while the divider works on a channel.
  assign idx = ch_q[IW-1:0];
  assign v_sel = sample_q[idx];
  assign lo_sel = range_low_q[idx];
  assign hi_sel = range_high_q[idx];
  assign is_flat = (hi_sel <= lo_sel);
  assign is_below = (v_sel <= lo_sel);
  assign is_above = (v_sel >= hi_sel);
  assign num_wide = (SW+1)'(v_sel) - (SW+1)'(lo_sel);
  assign den_wide = (SW+1)'(hi_sel) - (SW+1)'(lo_sel);

  // Shared restoring divider: one quotient bit per cycle.
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  assign last_ch = ((ch_q + CNT_W'(1)) == used);
  assign last_iter = (iter_q == (bits_eff - mmqp_pkg::QB_W'(1)));
  assign scan_last = (ch_q == CNT_W'(MAX_CHANNELS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      mmqp_pkg::ST_IDLE: begin
        if (accept && (req_type_i == mmqp_pkg::REQ_SCAN)) begin
          state_d = mmqp_pkg::ST_SCAN;
        end else if (accept && (req_type_i == mmqp_pkg::REQ_QUANT)) begin
          state_d = mmqp_pkg::ST_CHECK;
        end
      end
      mmqp_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = mmqp_pkg::ST_IDLE;
        end
      end
      mmqp_pkg::ST_CHECK: begin
        if (!is_flat && !is_below && !is_above) begin
          state_d = mmqp_pkg::ST_DIV;
        end else if (last_ch) begin
          state_d = mmqp_pkg::ST_IDLE;
        end
      end
      mmqp_pkg::ST_DIV: begin
        if (last_iter) begin
          state_d = last_ch ? mmqp_pkg::ST_IDLE : mmqp_pkg::ST_CHECK;
        end
      end
      default: begin
        state_d = mmqp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ch_d = ch_q;
    off_d = off_q;
    word_d = word_q;
    flat_d = flat_q;
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    iter_d = iter_q;
    done_d = 1'b0;
    packed_d = packed_q;
    flat_out_d = flat_out_q;
    merge = 1'b0;
    merge_code = '0;
    merge_flat = 1'b0;
    case (state_q)
      mmqp_pkg::ST_IDLE: begin
        ch_d = '0;
        off_d = '0;
        word_d = '0;
        flat_d = 1'b0;
      end
      mmqp_pkg::ST_SCAN: begin
        ch_d = ch_q + CNT_W'(1);
      end
      mmqp_pkg::ST_CHECK: begin
        if (is_flat) begin
          merge = 1'b1;
          merge_flat = 1'b1;
        end else if (is_below) begin
          merge = 1'b1;
        end else if (is_above) begin
          merge = 1'b1;
          merge_code = top;
        end else begin
          rem_d = num_wide[SW-1:0];
          den_d = den_wide[SW-1:0];
          quo_d = '0;
          iter_d = '0;
        end
      end
      mmqp_pkg::ST_DIV: begin
        rem_d = rem_ge ? SW'(rem_sh - {1'b0, den_q}) : rem_sh[SW-1:0];
        quo_d = {quo_q[CW-2:0], rem_ge};
        iter_d = iter_q + mmqp_pkg::QB_W'(1);
        if (last_iter) begin
          merge = 1'b1;
          merge_code = {quo_q[CW-2:0], rem_ge};
        end
      end
      default: begin
      end
    endcase
    if (merge) begin
      word_d = word_q | (mmqp_pkg::WORD_W'(merge_code) << off_q);
      flat_d = flat_q | merge_flat;
      ch_d = ch_q + CNT_W'(1);
      off_d = off_q + OFF_W'(bits_eff);
      if (last_ch) begin
        done_d = 1'b1;
        packed_d = word_d;
        flat_out_d = flat_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmqp_pkg::ST_IDLE;
      quant_bits_q <= mmqp_pkg::QB_RESET;
      channel_count_q <= mmqp_pkg::CC_RESET;
      ch_q <= '0;
      off_q <= '0;
      iter_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q <= ch_d;
      off_q <= off_d;
      iter_q <= iter_d;
      done_q <= done_d;
      if (cfg_write && (paddr[2] == mmqp_pkg::REG_QUANT_BITS)) begin
        quant_bits_q <= pwdata[mmqp_pkg::QB_W-1:0];
      end
      if (cfg_write && (paddr[2] == mmqp_pkg::REG_CHANNEL_COUNT)) begin
        channel_count_q <= pwdata[mmqp_pkg::CC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        range_low_q[c] <= SMAX;
        range_high_q[c] <= SMIN;
      end
    end else if (accept && (req_type_i == mmqp_pkg::REQ_CLEAR)) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        range_low_q[c] <= SMAX;
        range_high_q[c] <= SMIN;
      end
    end else if (state_q == mmqp_pkg::ST_SCAN) begin
      if (v_sel < lo_sel) begin
        range_low_q[idx] <= v_sel;
      end
      if (v_sel > hi_sel) begin
        range_high_q[idx] <= v_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        sample_q[c] <= sample_in[c];
      end
    end
    word_q <= word_d;
    flat_q <= flat_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    packed_q <= packed_d;
    flat_out_q <= flat_out_d;
  end

  assign done_o = done_q;
  assign packed_word_o = packed_q;
  assign flat_range_o = flat_out_q;

  `MMQP_ASSERT_IMP(a_done_when_idle, done_q, state_q == mmqp_pkg::ST_IDLE,
                   "Result strobe while a transaction is still in progress.")
  `MMQP_ASSERT_IMP(a_div_iter_bound, state_q == mmqp_pkg::ST_DIV, iter_q < bits_eff,
                   "Divider ran past the configured code width.")
  `MMQP_ASSERT_IMP(a_quant_ch_bound, state_q == mmqp_pkg::ST_CHECK, ch_q < used,
                   "Quantize step on a channel beyond the used count.")
  `MMQP_ASSERT_NXT(a_quant_starts, accept && (req_type_i == mmqp_pkg::REQ_QUANT),
                   state_q == mmqp_pkg::ST_CHECK && ch_q == '0,
                   "Quantize transaction did not start at the first channel.")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [2:0] ADDR_QB = {1'b0, mmqp_pkg::REG_QUANT_BITS, 2'b00};
  localparam logic [2:0] ADDR_CC = {1'b0, mmqp_pkg::REG_CHANNEL_COUNT, 2'b00};
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {ENT_ITEM, ENT_WRITE, ENT_DRAIN} entry_kind_e;
  typedef enum logic [1:0] {DRV_RUN, DRV_SETTLE, DRV_SETUP, DRV_ACCESS} drv_state_e;

  typedef struct {
    entry_kind_e      kind;
    mmqp_pkg::req_e   req;
    logic [3:0][31:0] smp;
    logic [2:0]       addr;
    logic [31:0]      data;
    int unsigned      idle_pct;
  } pending_t;

  typedef struct packed {
    logic [31:0] word;
    logic        flat;
  } quant_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [31:0] sample_ch0_i = '0;
  logic [31:0] sample_ch1_i = '0;
  logic [31:0] sample_ch2_i = '0;
  logic [31:0] sample_ch3_i = '0;
  logic        done_o;
  logic [31:0] packed_word_o;
  logic        flat_range_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  min_max_quantize_pack u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .sample_ch0_i  (sample_ch0_i),
    .sample_ch1_i  (sample_ch1_i),
    .sample_ch2_i  (sample_ch2_i),
    .sample_ch3_i  (sample_ch3_i),
    .done_o        (done_o),
    .packed_word_o (packed_word_o),
    .flat_range_o  (flat_range_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Predicted state of the block.
  logic signed [31:0] rng_lo [CHANNELS] = '{default: 32'sh7FFF_FFFF};
  logic signed [31:0] rng_hi [CHANNELS] = '{default: 32'sh8000_0000};
  logic [4:0]         qb_cfg = mmqp_pkg::QB_RESET;
  logic [2:0]         cc_cfg = mmqp_pkg::CC_RESET;
  quant_result_t      quant_exp [$];

  function automatic quant_result_t quantize_point(logic [3:0][31:0] smp);
    quant_result_t      res;
    int unsigned        bits;
    int unsigned        used;
    int unsigned        off;
    longint unsigned    num;
    longint unsigned    den;
    longint unsigned    code;
    longint unsigned    top;
    logic [63:0]        word;
    logic signed [31:0] v;
    bits = (qb_cfg < 2) ? 2 : ((qb_cfg > 16) ? 16 : qb_cfg);
    used = (cc_cfg < 1) ? 1 : ((cc_cfg > CHANNELS) ? CHANNELS : cc_cfg);
    top = (64'd1 << bits) - 1;
    word = '0;
    res.flat = 1'b0;
    for (int c = 0; c < used; c++) begin
      v = $signed(smp[c]);
      if (rng_hi[c] <= rng_lo[c]) begin
        code = 0;
        res.flat = 1'b1;
      end else if (v <= rng_lo[c]) begin
        code = 0;
      end else if (v >= rng_hi[c]) begin
        code = top;
      end else begin
        num = longint'(v) - longint'(rng_lo[c]);
        den = longint'(rng_hi[c]) - longint'(rng_lo[c]);
        code = (num << bits) / den;
        if (code > top) code = top;
      end
      off = c * bits;
      if (off < 32) word = word | (code << off);
    end
    res.word = word[31:0];
    return res;
  endfunction

  task automatic account_transaction(pending_t it);
    case (it.req)
      mmqp_pkg::REQ_CLEAR: begin
        for (int c = 0; c < CHANNELS; c++) begin
          rng_lo[c] = 32'sh7FFF_FFFF;
          rng_hi[c] = 32'sh8000_0000;
        end
      end
      mmqp_pkg::REQ_SCAN: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if ($signed(it.smp[c]) < rng_lo[c]) rng_lo[c] = $signed(it.smp[c]);
          if ($signed(it.smp[c]) > rng_hi[c]) rng_hi[c] = $signed(it.smp[c]);
        end
      end
      mmqp_pkg::REQ_QUANT: quant_exp.insert(quant_exp.size(), quantize_point(it.smp));
      default: ;
    endcase
  endtask

  // Driver.
  pending_t    pending [$];
  pending_t    held;
  bit          holding = 1'b0;
  bit          stim_done = 1'b0;
  drv_state_e  drv_state = DRV_RUN;
  int unsigned settle_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      case (drv_state)
        DRV_RUN: begin
          if (start && !busy) begin
            account_transaction(held);
            holding = 1'b0;
          end
          if (holding) begin
          end else if (pending.size() == 0) begin
            start <= 1'b0;
            stim_done <= 1'b1;
          end else if (pending[0].kind != ENT_ITEM) begin
            start <= 1'b0;
            settle_cnt = 0;
            drv_state <= DRV_SETTLE;
          end else if ($urandom_range(0, 99) < pending[0].idle_pct) begin
            start <= 1'b0;
          end else begin
            held = pending.pop_front();
            holding = 1'b1;
            start <= 1'b1;
            req_type_i <= held.req;
            sample_ch0_i <= held.smp[0];
            sample_ch1_i <= held.smp[1];
            sample_ch2_i <= held.smp[2];
            sample_ch3_i <= held.smp[3];
          end
        end
        DRV_SETTLE: begin
          if (quant_exp.size() == 0 && !busy) settle_cnt++;
          else settle_cnt = 0;
          if (settle_cnt >= SETTLE_CYCLES) begin
            if (pending[0].kind == ENT_DRAIN) begin
              void'(pending.pop_front());
              drv_state <= DRV_RUN;
            end else begin
              psel <= 1'b1;
              pwrite <= 1'b1;
              penable <= 1'b0;
              paddr <= pending[0].addr;
              pwdata <= pending[0].data;
              drv_state <= DRV_SETUP;
            end
          end
        end
        DRV_SETUP: begin
          penable <= 1'b1;
          drv_state <= DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_QB) qb_cfg = pwdata[4:0];
            else if (paddr == ADDR_CC) cc_cfg = pwdata[2:0];
            void'(pending.pop_front());
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            drv_state <= DRV_RUN;
          end
        end
        default: drv_state <= DRV_RUN;
      endcase
    end
  end

  // Monitor.
  int unsigned mismatches = 0;

  always @(posedge clk_i) begin : result_check
    quant_result_t exp_r;
    if (rst_ni && done_o) begin
      if (quant_exp.size() == 0) begin
        $error("unexpected result: packed_word %h flat_range %b", packed_word_o, flat_range_o);
        mismatches++;
      end else begin
        exp_r = quant_exp.pop_front();
        if (packed_word_o !== exp_r.word) begin
          $error("packed_word expected %h actual %h", exp_r.word, packed_word_o);
          mismatches++;
        end
        if (flat_range_o !== exp_r.flat) begin
          $error("flat_range expected %b actual %b", exp_r.flat, flat_range_o);
          mismatches++;
        end
      end
    end
  end

  // Stimulus generation.
  int unsigned        gen_idle = 0;
  int unsigned        gen_count = 0;
  int unsigned        gen_mode = 0;
  int unsigned        gen_spread = 0;
  logic [31:0]        gen_base = '0;
  logic signed [31:0] gen_lo [CHANNELS] = '{default: 32'sh7FFF_FFFF};
  logic signed [31:0] gen_hi [CHANNELS] = '{default: 32'sh8000_0000};

  function automatic logic [3:0][31:0] lanes(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c, logic [31:0] d);
    return {d, c, b, a};
  endfunction

  function automatic logic [3:0][31:0] rand_lanes();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  task automatic add_item(mmqp_pkg::req_e req, logic [3:0][31:0] smp);
    pending_t it;
    it.kind = ENT_ITEM;
    it.req = req;
    it.smp = smp;
    it.addr = '0;
    it.data = '0;
    it.idle_pct = gen_idle;
    pending.insert(pending.size(), it);
    if (req != mmqp_pkg::REQ_NONE) gen_count++;
    for (int c = 0; c < CHANNELS; c++) begin
      if (req == mmqp_pkg::REQ_CLEAR) begin
        gen_lo[c] = 32'sh7FFF_FFFF;
        gen_hi[c] = 32'sh8000_0000;
      end else if (req == mmqp_pkg::REQ_SCAN) begin
        if ($signed(smp[c]) < gen_lo[c]) gen_lo[c] = $signed(smp[c]);
        if ($signed(smp[c]) > gen_hi[c]) gen_hi[c] = $signed(smp[c]);
      end
    end
  endtask

  task automatic add_ctrl(entry_kind_e kind, logic [2:0] addr, logic [31:0] value);
    pending_t it;
    it.kind = kind;
    it.req = mmqp_pkg::REQ_NONE;
    it.smp = '0;
    it.addr = addr;
    it.data = value;
    it.idle_pct = gen_idle;
    pending.insert(pending.size(), it);
  endtask

  task automatic add_config(logic [4:0] qb, logic [2:0] cc);
    add_ctrl(ENT_WRITE, ADDR_QB, ($urandom() & ~32'h1F) | 32'(qb));
    add_ctrl(ENT_WRITE, ADDR_CC, ($urandom() & ~32'h7) | 32'(cc));
  endtask

  function automatic logic [31:0] scan_value();
    case (gen_mode)
      0: return $urandom();
      1: return gen_base + $urandom_range(0, gen_spread);
      default: begin
        case ($urandom_range(0, 3))
          0: return S_MIN;
          1: return S_MAX;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] quant_value(int ch);
    longint span;
    span = longint'(gen_hi[ch]) - longint'(gen_lo[ch]);
    case ($urandom_range(0, 9))
      0: return gen_lo[ch];
      1: return gen_hi[ch];
      2: return gen_lo[ch] - $urandom_range(1, 1000);
      3: return gen_hi[ch] + $urandom_range(1, 1000);
      4: return $urandom();
      default: begin
        if (span <= 0) return $urandom();
        return 32'(longint'(gen_lo[ch]) + longint'({$urandom(), $urandom()} % span));
      end
    endcase
  endfunction

  task automatic add_sequence();
    logic [3:0][31:0] smp;
    logic [3:0]       flat_mask;
    logic [31:0]      flat_val;
    int unsigned      r;
    r = $urandom_range(0, 9);
    if (r < 8) begin
      if ($urandom_range(0, 7) != 0) add_item(mmqp_pkg::REQ_CLEAR, rand_lanes());
      gen_mode = $urandom_range(0, 2);
      gen_base = $urandom();
      gen_spread = $urandom() >> $urandom_range(0, 31);
      flat_mask = ($urandom_range(0, 4) == 0) ? 4'($urandom()) : 4'b0000;
      flat_val = scan_value();
      repeat ($urandom_range(1, 6)) begin
        for (int c = 0; c < CHANNELS; c++) smp[c] = flat_mask[c] ? flat_val : scan_value();
        add_item(mmqp_pkg::REQ_SCAN, smp);
      end
      repeat ($urandom_range(1, 6)) begin
        for (int c = 0; c < CHANNELS; c++) smp[c] = quant_value(c);
        add_item(mmqp_pkg::REQ_QUANT, smp);
      end
    end else if (r == 8) begin
      repeat ($urandom_range(1, 4)) begin
        add_item(mmqp_pkg::req_e'($urandom_range(0, 3)), rand_lanes());
      end
    end else begin
      add_item(mmqp_pkg::REQ_CLEAR, rand_lanes());
      if ($urandom_range(0, 1) != 0) add_item(mmqp_pkg::REQ_SCAN, rand_lanes());
      add_item(mmqp_pkg::REQ_QUANT, rand_lanes());
    end
  endtask

  initial begin : stimulus
    int unsigned qb_set [12];
    int unsigned cc_set [12];
    int unsigned idle_set [3];
    int unsigned phase_start;
    bit          drained;
    qb_set = '{8, 2, 16, 5, 11, 16, 2, 0, 31, 9, 1, 17};
    cc_set = '{1, 4, 4, 3, 3, 1, 1, 0, 7, 4, 5, 6};
    idle_set = '{0, 57, 6};

    gen_idle = 0;
    add_item(mmqp_pkg::REQ_QUANT, lanes(32'h0, 32'h0, 32'h0, 32'h0));
    add_item(mmqp_pkg::REQ_NONE, rand_lanes());
    add_item(mmqp_pkg::REQ_SCAN, lanes(S_MIN, S_MIN, S_MIN, S_MIN));
    add_item(mmqp_pkg::REQ_SCAN, lanes(S_MAX, S_MAX, S_MAX, S_MAX));
    add_item(mmqp_pkg::REQ_QUANT, lanes(S_MIN, S_MAX, 32'h0, 32'hFFFF_FFFF));
    add_item(mmqp_pkg::REQ_QUANT, lanes(S_MAX, S_MIN, 32'h0, 32'h0));
    add_item(mmqp_pkg::REQ_QUANT, lanes(32'h0, 32'h0, 32'h0, 32'h0));
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'h4000_0000, 32'hC000_0000, 32'h1, 32'h7FFF_FFFE));
    add_config(5'd16, 3'd4);
    add_item(mmqp_pkg::REQ_QUANT, lanes(S_MIN, S_MAX, 32'h0, 32'h1));
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'hFFFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001, 32'h4000_0000));
    add_item(mmqp_pkg::REQ_CLEAR, rand_lanes());
    add_item(mmqp_pkg::REQ_QUANT, lanes(32'h0, 32'h0, 32'h0, 32'h0));
    add_item(mmqp_pkg::REQ_SCAN,
             lanes(32'h000A_0000, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000));
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'h000A_0000, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000));
    add_item(mmqp_pkg::REQ_SCAN,
             lanes(32'h0014_0000, 32'hFFE2_0000, 32'h0028_0000, 32'h0005_0000));
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'h0005_0000, 32'hFF00_0000, 32'h0001_0000, 32'h0000_0000));
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000));
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'h000F_0000, 32'hFFF6_0000, 32'h0019_0000, 32'h0007_8000));
    add_config(5'd0, 3'd0);
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'h000F_0000, 32'hFFF6_0000, 32'h0019_0000, 32'h0007_8000));
    add_config(5'd31, 3'd7);
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'h000F_0000, 32'hFFF6_0000, 32'h0019_0000, 32'h0007_8000));
    add_config(5'd11, 3'd3);
    add_item(mmqp_pkg::REQ_QUANT,
             lanes(32'h000F_0000, 32'hFFF6_0000, 32'h0019_0000, 32'h0007_8000));

    for (int p = 0; p < 12; p++) begin
      gen_idle = idle_set[p % 3];
      add_config(5'(qb_set[p]), 3'(cc_set[p]));
      phase_start = gen_count;
      drained = 1'b0;
      while (gen_count - phase_start < 100) begin
        // Let the block run dry once per phase before continuing.
        if (!drained && gen_count - phase_start >= 50) begin
          add_ctrl(ENT_DRAIN, '0, '0);
          drained = 1'b1;
        end
        add_sequence();
      end
    end
  end

  initial begin
    wait (rst_ni);
    while (!(stim_done && quant_exp.size() == 0)) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
